@@ hdl/swap_run_bitmap_allocator_unit_assert.svh @@
// assertion macros for the swap run bitmap allocator
// expects aclk and aresetn in the scope of each use
`ifndef SWAP_RUN_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define SWAP_RUN_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sra_pkg.sv @@
// shared types and constants of the swap run bitmap allocator
// no dependencies
package sra_pkg;

    localparam int WORD_W   = 64;
    localparam int WORD_LW  = 6;
    localparam int CARRY_W  = 7;
    localparam int DISK_W   = 13;
    localparam int SECTOR_W = 12;
    localparam int SLOT_W   = 12;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic               found;
        logic [WORD_LW-1:0] offset;
        logic [CARRY_W-1:0] carry;
    } fit_t;

endpackage

@@ hdl/sra_word_fit.sv @@
// first-fit search over one map word, with free run carried in from lower words
// depends on sra_pkg
module sra_word_fit
    import sra_pkg::*;
#(
    parameter int RUN_LEN = 8
) (
    input  logic [WORD_W-1:0]  word,
    input  logic [CARRY_W-1:0] carry_in,
    input  logic [WORD_LW:0]   lim,
    output fit_t               fit
);

    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] fit_vec;
    logic [WORD_W-1:0] suffix_free;

    genvar j;
    generate
        for (j = 0; j < WORD_W; j++) begin : g_bit
            assign free_bits[j] = ~word[j] && (lim > (WORD_LW + 1)'(j));
            assign suffix_free[j] = &free_bits[WORD_W-1:j];
            if (j + 1 >= RUN_LEN) begin : g_inword
                assign fit_vec[j] = &free_bits[j -: RUN_LEN];
            end else begin : g_span
                assign fit_vec[j] = (&free_bits[j:0])
                    && (carry_in >= CARRY_W'(RUN_LEN - 1 - j));
            end
        end
    endgenerate

    always_comb begin
        logic [CARRY_W-1:0] cnt;
        fit.found  = 1'b0;
        fit.offset = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (fit_vec[k]) begin
                fit.found  = 1'b1;
                fit.offset = WORD_LW'(k);
            end
        end
        // length of the free run at the top of the word, found from its lowest bit
        cnt = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (suffix_free[k]) begin
                cnt = CARRY_W'(WORD_W - k);
            end
        end
        fit.carry = (cnt >= CARRY_W'(RUN_LEN)) ? CARRY_W'(RUN_LEN) : cnt;
    end

endmodule

@@ hdl/swap_run_bitmap_allocator_unit.sv @@
// top level of the swap run bitmap allocator: map memory, sequencer, result register
// depends on sra_pkg, sra_word_fit and swap_run_bitmap_allocator_unit_assert.svh
//
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_opcode, s_start_sector
// m_        out        m_valid / m_ready    m_status, m_slot_start
// cfg_      in         cfg_valid/cfg_ready  cfg_data (disk_sectors)
//
// allocate: scans the 64-bit map words in turn, at most ceil(size/64) words,
// then reads and rewrites each map word the run touches
// free: rewrites each map word the run touches; a range error skips to the result
// after reset the map is cleared one word a cycle, ceil(MAX_SECTORS/64) words
// a stalled result holds the finished request in place until the output frees up
`include "swap_run_bitmap_allocator_unit_assert.svh"

module swap_run_bitmap_allocator_unit
    import sra_pkg::*;
#(
    parameter int MAX_SECTORS = 4096,
    parameter int RUN_LEN     = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [SECTOR_W-1:0] s_start_sector,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_slot_start,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DISK_W-1:0]   cfg_data
);

    localparam int W     = WORD_W;
    localparam int LW    = WORD_LW;
    localparam int DEPTH = (MAX_SECTORS + W - 1) / W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = AW + LW;
    localparam int EW    = (((BW + 1) > DISK_W) ? (BW + 1) : DISK_W) + 1;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_SCAN    = 6'b000100,
        ST_MARK_RD = 6'b001000,
        ST_MARK_WR = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [AW-1:0]       scan_rd_reg, scan_rd_next;
    logic [AW-1:0]       proc_reg, proc_next;
    logic                pend_reg, pend_next;
    logic [CARRY_W-1:0]  carry_reg, carry_next;
    logic                op_reg, op_next;
    logic [EW-1:0]       s_reg, s_next;
    logic [EW-1:0]       e_reg, e_next;
    logic [AW-1:0]       mark_addr_reg, mark_addr_next;
    logic [AW-1:0]       last_word_reg, last_word_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic [DISK_W-1:0]   disk_reg, disk_next;
    logic [W-1:0]        rdata_reg;

    logic [W-1:0]        map_mem [DEPTH];
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [W-1:0]        wr_data;

    logic [EW-1:0]       size_w;
    logic [EW-1:0]       scan_base;
    logic [EW-1:0]       mark_base;
    logic [EW-1:0]       start_w;
    logic [EW-1:0]       free_end;
    logic [EW-1:0]       slot_w;
    logic [EW-1:0]       cand_s;
    logic [EW-1:0]       cand_e;
    logic [LW:0]         lim;
    logic [W-1:0]        run_mask;
    fit_t                fit;

    assign size_w = (EW'(disk_reg) > EW'(MAX_SECTORS)) ? EW'(MAX_SECTORS) : EW'(disk_reg);
    assign scan_base = EW'({proc_reg, LW'(0)});
    assign mark_base = EW'({mark_addr_reg, LW'(0)});
    assign start_w   = EW'(s_start_sector);
    assign free_end  = start_w + EW'(RUN_LEN);
    assign slot_w    = scan_base + EW'(fit.offset) + EW'(1) - EW'(RUN_LEN);
    assign cand_s    = (state_reg == ST_SCAN) ? slot_w : start_w;
    assign cand_e    = cand_s + EW'(RUN_LEN - 1);

    always_comb begin
        logic [EW-1:0] diff;
        diff = size_w - scan_base;
        if (size_w > scan_base) begin
            lim = (diff >= EW'(W)) ? (LW + 1)'(W) : diff[LW:0];
        end else begin
            lim = '0;
        end
    end

    sra_word_fit #(
        .RUN_LEN (RUN_LEN)
    ) u_fit (
        .word     (rdata_reg),
        .carry_in (carry_reg),
        .lim      (lim),
        .fit      (fit)
    );

    always_comb begin
        logic [EW-1:0] pos;
        for (int j = 0; j < W; j++) begin
            pos = mark_base + EW'(j);
            run_mask[j] = (pos >= s_reg) && (pos <= e_reg);
        end
    end

    assign rd_addr = (state_reg == ST_SCAN) ? scan_rd_reg : mark_addr_reg;
    assign wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_MARK_WR);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : mark_addr_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 :
                     (op_reg == OP_ALLOC) ? (rdata_reg | run_mask) : (rdata_reg & ~run_mask);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= map_mem[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        scan_rd_next    = scan_rd_reg;
        proc_next       = proc_reg;
        pend_next       = pend_reg;
        carry_next      = carry_reg;
        op_next         = op_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        mark_addr_next  = mark_addr_reg;
        last_word_next  = last_word_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        disk_next       = disk_reg;

        if (cfg_valid) begin
            disk_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next = s_opcode;
                    if (s_opcode == OP_ALLOC) begin
                        scan_rd_next = '0;
                        pend_next    = 1'b0;
                        carry_next   = '0;
                        state_next   = ST_SCAN;
                    end else if (free_end > size_w) begin
                        res_status_next = ST_RANGE;
                        res_slot_next   = '0;
                        state_next      = ST_DONE;
                    end else begin
                        s_next          = cand_s;
                        e_next          = cand_e;
                        mark_addr_next  = cand_s[BW-1:LW];
                        last_word_next  = cand_e[BW-1:LW];
                        res_status_next = ST_OK;
                        res_slot_next   = '0;
                        state_next      = ST_MARK_RD;
                    end
                end
            end
            ST_SCAN: begin
                scan_rd_next = scan_rd_reg + AW'(1);
                proc_next    = scan_rd_reg;
                pend_next    = 1'b1;
                if (pend_reg) begin
                    if (fit.found) begin
                        s_next          = cand_s;
                        e_next          = cand_e;
                        mark_addr_next  = cand_s[BW-1:LW];
                        last_word_next  = cand_e[BW-1:LW];
                        res_status_next = ST_OK;
                        res_slot_next   = slot_w[SLOT_W-1:0];
                        state_next      = ST_MARK_RD;
                    end else if (scan_base + EW'(W) >= size_w) begin
                        res_status_next = ST_NO_SPACE;
                        res_slot_next   = '0;
                        state_next      = ST_DONE;
                    end else begin
                        carry_next = fit.carry;
                    end
                end
            end
            ST_MARK_RD: begin
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                if (mark_addr_reg == last_word_reg) begin
                    state_next = ST_DONE;
                end else begin
                    mark_addr_next = mark_addr_reg + AW'(1);
                    state_next     = ST_MARK_RD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            disk_reg     <= DISK_W'(4096);
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
            disk_reg     <= disk_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_rd_reg    <= scan_rd_next;
        proc_reg       <= proc_next;
        carry_reg      <= carry_next;
        op_reg         <= op_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        mark_addr_reg  <= mark_addr_next;
        last_word_reg  <= last_word_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot_start = m_slot_reg;

    // a found run lies inside the usable size
    `SRA_ASSERT_NEXT(a_run_in_size, (state_reg == ST_SCAN && state_next == ST_MARK_RD), (e_reg < size_w), "allocated run beyond usable size")
    // only defined status codes leave the block
    `SRA_ASSERT_NOW(a_status_code, m_valid, (m_status == ST_OK || m_status == ST_NO_SPACE || m_status == ST_RANGE), "undefined status code")
    // failed requests report slot zero
    `SRA_ASSERT_NOW(a_slot_zero, (m_valid && m_status != ST_OK), (m_slot_start == '0), "slot not zero on failed request")
    // map updates stay within the run's words
    `SRA_ASSERT_NOW(a_mark_bound, (state_reg == ST_MARK_WR), (mark_addr_reg <= last_word_reg && run_mask != '0), "map write outside run")

endmodule
